[sv/stp_pkg.sv]
// shared types and constants of the trapezoidal stepper profile block
package stp_pkg;

  localparam int unsigned VEL_W     = 18;
  localparam int unsigned ACC_W     = 22;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 22;
  localparam int unsigned OUT_DLY_W = 10;
  localparam int unsigned NUM_W     = 40;
  localparam int unsigned PROD_W    = CNT_W + ACC_W;
  localparam int unsigned DEN_W     = PROD_W + 1;
  localparam int unsigned ROOT_W    = NUM_W / 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VELOCITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCELERATION = 2'd1;

  localparam logic [VEL_W-1:0] RST_MAX_VELOCITY = 18'd1600;
  localparam logic [ACC_W-1:0] RST_ACCELERATION = 22'd16000;

  localparam int unsigned START_DELAY    = 10;
  localparam int unsigned ZERO_VEL_DELAY = 1000;

  localparam logic [NUM_W-1:0] ONE_E12 = 40'd1000000000000;
  localparam logic [NUM_W-1:0] ONE_E6  = 40'd1000000;

  typedef struct packed {
    logic               op;
    logic signed [31:0] target_steps;
  } stp_in_t;

  typedef struct packed {
    logic                 step_level;
    logic                 dir_level;
    logic [9:0]           next_delay_us;
    logic signed [31:0]   position_steps;
    logic                 moving;
  } stp_out_t;

  typedef struct packed {
    logic cap_in;
    logic start_load;
    logic acc_div_go;
    logic acc_split;
    logic tick_edge;
    logic zero_level;
    logic tick_finish;
    logic mul_load;
    logic ramp_div_go;
    logic coast_div_go;
    logic sqrt_go;
    logic delay_from_sqrt;
    logic delay_from_div;
    logic delay_zero_vel;
    logic emit;
  } stp_cmd_t;

  typedef struct packed {
    logic op;
    logic idle;
    logic phase;
    logic last;
    logic in_accel;
    logic in_coast;
    logic v_zero;
    logic x_zero;
    logic div_done;
    logic sqrt_done;
  } stp_sts_t;

endpackage

[sv/stepper_trapezoid_profile_top.sv]
// top level of the trapezoidal stepper profile generator
//
// in_* carries one item per valid/ready handshake: a start (op 0) with an
// absolute target, or a step timer expiry (op 1). Each item gives exactly
// one item on out_*: step pin level, direction pin, the next timer delay in
// microseconds, the position and the moving flag.
// cfg_we writes max_velocity (index 0) or acceleration (index 1); other
// indexes are ignored. Write only while the block is idle.
// From accept to result register, a start runs the divide for the
// accelerate count. A timer item on the phase-low edge of a step, or while
// idle, goes straight to the result; on the phase-high edge a ramp step
// runs a multiply, a divide and a square root, a coast step a divide,
// and the last step of a move none of these. Items are worked one at a
// time; the next item can be taken in the cycle after the result
// register loads.
// The result sits in an output register, so a new item is taken while the
// previous result waits; when the receiver stalls, a finished result waits
// in the controller until the output register frees.
// Reset (synchronous, rst_n low) sets position 0, idle, positive direction,
// delay 1000 and the register defaults 1600 and 16000.
module stepper_trapezoid_profile_top import stp_pkg::*; #(
  parameter int unsigned POSITION_BITS = 32,
  parameter int unsigned MAX_DELAY_US  = 1000
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  stp_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output stp_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  stp_cmd_t cmd;
  stp_sts_t sts;

  stp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  stp_dp #(
    .POSITION_BITS (POSITION_BITS),
    .MAX_DELAY_US  (MAX_DELAY_US)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

[sv/stp_div.sv]
// iterative restoring divider, one quotient bit per cycle
module stp_div import stp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int unsigned IT_W = $clog2(NUM_W + 1);

  logic             busy_r, done_r;
  logic [IT_W-1:0]  cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r, rem_r;
  logic [DEN_W:0]   sh, diff;
  logic             qbit;

  assign sh   = {rem_r, num_r[NUM_W-1]};
  assign diff = sh - {1'b0, den_r};
  assign qbit = ~diff[DEN_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= IT_W'(NUM_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], qbit};
      rem_r <= qbit ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

[sv/stp_sqrt.sv]
// iterative integer square root, one root bit per cycle
module stp_sqrt import stp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [NUM_W-1:0]  x,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int unsigned IT_W = $clog2(ROOT_W + 1);

  logic              busy_r, done_r;
  logic [IT_W-1:0]   cnt_r;
  logic [NUM_W-1:0]  x_r;
  logic [ROOT_W:0]   rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [ROOT_W+2:0] sh, trial, diff;
  logic              ge;

  assign sh    = {rem_r, x_r[NUM_W-1 -: 2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign ge    = sh >= trial;
  assign diff  = sh - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= IT_W'(ROOT_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      x_r    <= x;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r    <= {x_r[NUM_W-3:0], 2'b00};
      rem_r  <= ge ? diff[ROOT_W:0] : sh[ROOT_W:0];
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

[sv/stp_dp.sv]
// datapath: profile registers, step counters, multiplier, divider and square root
module stp_dp import stp_pkg::*; #(
  parameter int unsigned POSITION_BITS = 32,
  parameter int unsigned MAX_DELAY_US  = 1000
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  input  stp_in_t              in_data,
  input  stp_cmd_t             cmd,
  output stp_sts_t             sts,
  output stp_out_t             out_data
);

  localparam int unsigned DLY_MAX =
    (MAX_DELAY_US > ZERO_VEL_DELAY) ? MAX_DELAY_US : ZERO_VEL_DELAY;
  localparam int unsigned DLY_W = $clog2(DLY_MAX + 1);
  localparam int unsigned WID   = ((POSITION_BITS > 32) ? POSITION_BITS : 32) + 2;
  localparam int unsigned ZV_DLY =
    (ZERO_VEL_DELAY > MAX_DELAY_US) ? MAX_DELAY_US : ZERO_VEL_DELAY;

  logic [VEL_W-1:0]         max_vel_r;
  logic [ACC_W-1:0]         accel_r;
  stp_in_t                  in_r;
  logic [POSITION_BITS-1:0] pos_r;
  logic                     phase_r, dirneg_r, level_r;
  logic [CNT_W-1:0]         total_r, accelc_r, coast_r, done_r;
  logic [DLY_W-1:0]         delay_r;
  logic [DEN_W-1:0]         x_r;
  stp_out_t                 out_r;

  logic [WID-1:0]    tgt_x, pos_x, delta, mag;
  logic              neg;
  logic [CNT_W-1:0]  span;
  logic [35:0]       vsq;
  logic [36:0]       vv_sum;
  logic [CNT_W-1:0]  acc_sat;
  logic [CNT_W:0]    two_acc;
  logic [CNT_W:0]    a_end;
  logic [CNT_W-1:0]  steps;
  logic [PROD_W-1:0] prod;
  logic              div_go, div_done, sqrt_done;
  logic [NUM_W-1:0]  div_num, quo;
  logic [DEN_W-1:0]  div_den;
  logic [ROOT_W-1:0] root;

  function automatic logic [DLY_W-1:0] cap_delay(input logic [NUM_W-1:0] v);
    cap_delay = (v > NUM_W'(MAX_DELAY_US)) ? DLY_W'(MAX_DELAY_US) : DLY_W'(v);
  endfunction

  // start move
  assign tgt_x = {{(WID-32){in_r.target_steps[31]}}, in_r.target_steps};
  assign pos_x = {{(WID-POSITION_BITS){pos_r[POSITION_BITS-1]}}, pos_r};
  assign delta = tgt_x - pos_x;
  assign neg   = delta[WID-1];
  assign mag   = neg ? (~delta + 1'b1) : delta;
  assign span  = (|mag[WID-1:CNT_W]) ? '1 : mag[CNT_W-1:0];

  assign vsq     = max_vel_r * max_vel_r;
  assign vv_sum  = 37'(vsq) + 37'(accel_r);
  assign acc_sat = ((accel_r == '0) || (|quo[NUM_W-1:CNT_W])) ? '1 : quo[CNT_W-1:0];
  assign two_acc = {acc_sat, 1'b0};

  // step region
  assign a_end = {1'b0, accelc_r} + {1'b0, coast_r};
  assign steps = (done_r < accelc_r) ? done_r : (total_r - done_r);
  assign prod  = steps * accel_r;

  always_comb begin
    div_go  = cmd.acc_div_go | cmd.ramp_div_go | cmd.coast_div_go;
    div_num = ONE_E6;
    div_den = DEN_W'(max_vel_r);
    if (cmd.acc_div_go) begin
      div_num = NUM_W'(vv_sum);
      div_den = DEN_W'({accel_r, 1'b0});
    end else if (cmd.ramp_div_go) begin
      div_num = ONE_E12;
      div_den = x_r;
    end
  end

  stp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  stp_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.sqrt_go),
    .x     (quo),
    .done  (sqrt_done),
    .root  (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_vel_r <= RST_MAX_VELOCITY;
      accel_r   <= RST_ACCELERATION;
      pos_r     <= '0;
      phase_r   <= 1'b0;
      dirneg_r  <= 1'b0;
      total_r   <= '0;
      accelc_r  <= '0;
      coast_r   <= '0;
      done_r    <= '0;
      delay_r   <= DLY_W'(ZERO_VEL_DELAY);
      level_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MAX_VELOCITY: max_vel_r <= cfg_wdata[VEL_W-1:0];
          CFG_ACCELERATION: accel_r   <= cfg_wdata[ACC_W-1:0];
          default: ;
        endcase
      end
      if (cmd.start_load) begin
        dirneg_r <= neg;
        total_r  <= span;
        done_r   <= '0;
        delay_r  <= DLY_W'(START_DELAY);
        level_r  <= 1'b0;
      end
      if (cmd.acc_split) begin
        if (two_acc > {1'b0, total_r}) begin
          accelc_r <= total_r >> 1;
          coast_r  <= '0;
        end else begin
          accelc_r <= acc_sat;
          coast_r  <= total_r - two_acc[CNT_W-1:0];
        end
      end
      if (cmd.zero_level) begin
        level_r <= 1'b0;
      end
      if (cmd.tick_edge) begin
        level_r <= phase_r;
        phase_r <= ~phase_r;
        if (phase_r) begin
          done_r <= done_r + 1'b1;
          pos_r  <= dirneg_r ? (pos_r - 1'b1) : (pos_r + 1'b1);
        end
      end
      if (cmd.tick_finish) begin
        done_r  <= '0;
        total_r <= '0;
      end
      if (cmd.delay_zero_vel) begin
        delay_r <= DLY_W'(ZV_DLY);
      end
      if (cmd.delay_from_div) begin
        delay_r <= cap_delay(quo);
      end
      if (cmd.delay_from_sqrt) begin
        delay_r <= cap_delay(NUM_W'(root));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      in_r <= in_data;
    end
    if (cmd.mul_load) begin
      x_r <= {prod, 1'b0};
    end
    if (cmd.emit) begin
      out_r.step_level     <= level_r;
      out_r.dir_level      <= ~dirneg_r;
      out_r.next_delay_us  <= OUT_DLY_W'(delay_r);
      out_r.position_steps <= 32'(pos_r);
      out_r.moving         <= total_r != '0;
    end
  end

  always_comb begin
    sts.op        = in_r.op;
    sts.idle      = total_r == '0;
    sts.phase     = phase_r;
    sts.last      = done_r == total_r;
    sts.in_accel  = done_r < accelc_r;
    sts.in_coast  = {1'b0, done_r} < a_end;
    sts.v_zero    = max_vel_r == '0;
    sts.x_zero    = x_r == '0;
    sts.div_done  = div_done;
    sts.sqrt_done = sqrt_done;
  end

  assign out_data = out_r;

endmodule

[sv/stp_ctrl.sv]
// controller: sequences one item at a time through the datapath
module stp_ctrl import stp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  stp_sts_t sts,
  output stp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_START,
    S_ACC_WAIT,
    S_REGION,
    S_MUL,
    S_RAMP_WAIT,
    S_SQRT_WAIT,
    S_COAST_WAIT,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_free  = ~out_valid_r | out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts.op) begin
          cmd.start_load = 1'b1;
          state_nxt      = S_START;
        end else if (sts.idle) begin
          cmd.zero_level = 1'b1;
          state_nxt      = S_EMIT;
        end else begin
          cmd.tick_edge = 1'b1;
          state_nxt     = sts.phase ? S_REGION : S_EMIT;
        end
      end
      S_START: begin
        cmd.acc_div_go = 1'b1;
        state_nxt      = S_ACC_WAIT;
      end
      S_ACC_WAIT: begin
        if (sts.div_done) begin
          cmd.acc_split = 1'b1;
          state_nxt     = S_EMIT;
        end
      end
      S_REGION: begin
        if (sts.last) begin
          cmd.tick_finish = 1'b1;
          state_nxt       = S_EMIT;
        end else if (sts.in_accel || !sts.in_coast) begin
          cmd.mul_load = 1'b1;
          state_nxt    = S_MUL;
        end else if (sts.v_zero) begin
          cmd.delay_zero_vel = 1'b1;
          state_nxt          = S_EMIT;
        end else begin
          cmd.coast_div_go = 1'b1;
          state_nxt        = S_COAST_WAIT;
        end
      end
      S_MUL: begin
        if (sts.x_zero) begin
          cmd.delay_zero_vel = 1'b1;
          state_nxt          = S_EMIT;
        end else begin
          cmd.ramp_div_go = 1'b1;
          state_nxt       = S_RAMP_WAIT;
        end
      end
      S_RAMP_WAIT: begin
        if (sts.div_done) begin
          cmd.sqrt_go = 1'b1;
          state_nxt   = S_SQRT_WAIT;
        end
      end
      S_SQRT_WAIT: begin
        if (sts.sqrt_done) begin
          cmd.delay_from_sqrt = 1'b1;
          state_nxt           = S_EMIT;
        end
      end
      S_COAST_WAIT: begin
        if (sts.div_done) begin
          cmd.delay_from_div = 1'b1;
          state_nxt          = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r & ~out_ready;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
